FILE: rtl/core/scfr_pkg.sv
// scfr_pkg: shared constants, result type and crc-8 byte update for the
// sync crc8 frame receiver. no dependencies.
`default_nettype none

package scfr_pkg;

  localparam int FRAME_LEN = 10;

  localparam logic [7:0] CRC_POLY  = 8'h8C;
  localparam logic [7:0] CRC_INIT  = 8'h00;
  localparam logic [7:0] SYNC_RESET = 8'd90;

  localparam logic [3:0] POS_LAST    = 4'(FRAME_LEN - 1);
  localparam logic [3:0] POS_CRC_END = 4'(FRAME_LEN - 2);
  localparam logic [3:0] POS_LEFT_LO  = 4'd1;
  localparam logic [3:0] POS_LEFT_HI  = 4'd4;
  localparam logic [3:0] POS_RIGHT_LO = 4'd5;
  localparam logic [3:0] POS_RIGHT_HI = 4'd8;

  localparam int         PADDR_W      = 3;
  localparam logic       REG_SYNC_IDX = 1'b0;

  localparam int RESULT_W = 65;
  localparam int M_DATA_W = 72;

  typedef struct packed {
    logic signed [31:0] right_count;
    logic signed [31:0] left_count;
    logic               frame_ok;
  } result_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                             input logic [7:0] b_in);
    logic [7:0] c;
    logic [7:0] d;
    logic       mix;
    c = crc_in;
    d = b_in;
    for (int k = 0; k < 8; k++) begin
      mix = c[0] ^ d[0];
      c = c >> 1;
      if (mix) begin
        c = c ^ CRC_POLY;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/scfr_frame.sv
// scfr_frame: sync hunt, byte position, running crc and count assembly.
// depends on scfr_pkg.
`default_nettype none

module scfr_frame (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        sync_byte,
  input  wire logic              in_accept,
  input  wire logic [7:0]        in_byte,
  output logic                   res_push,
  output scfr_pkg::result_t      res_data
);
  import scfr_pkg::*;

  logic        in_frame, in_frame_next;
  logic [3:0]  pos, pos_next;
  logic [7:0]  crc, crc_next;
  logic [31:0] left_asm, left_next;
  logic [31:0] right_asm, right_next;

  logic        active;
  logic [3:0]  p;
  logic [7:0]  crc_cur;
  logic [31:0] left_cur, right_cur;
  logic [3:0]  pm1, pm5;
  logic        ok;

  always_comb begin
    active    = in_frame || (in_byte == sync_byte);
    p         = in_frame ? pos : 4'd0;
    crc_cur   = in_frame ? crc : CRC_INIT;
    left_cur  = in_frame ? left_asm : 32'd0;
    right_cur = in_frame ? right_asm : 32'd0;
    pm1       = p - POS_LEFT_LO;
    pm5       = p - POS_RIGHT_LO;
    ok        = (crc_cur == in_byte);

    in_frame_next = in_frame;
    pos_next      = pos;
    crc_next      = crc;
    left_next     = left_asm;
    right_next    = right_asm;
    res_push      = 1'b0;
    res_data.frame_ok    = ok;
    res_data.left_count  = ok ? left_cur : 32'sd0;
    res_data.right_count = ok ? right_cur : 32'sd0;

    if (in_accept && active) begin
      if (p == POS_LAST) begin
        res_push      = 1'b1;
        in_frame_next = 1'b0;
        pos_next      = 4'd0;
        crc_next      = CRC_INIT;
        left_next     = 32'd0;
        right_next    = 32'd0;
      end else begin
        in_frame_next = 1'b1;
        pos_next      = p + 4'd1;
        crc_next      = (p < POS_CRC_END) ? crc8_update(crc_cur, in_byte) : crc_cur;
        left_next     = left_cur;
        right_next    = right_cur;
        if (p >= POS_LEFT_LO && p <= POS_LEFT_HI) begin
          left_next[{pm1[1:0], 3'b000} +: 8] = in_byte;
        end else if (p >= POS_RIGHT_LO && p <= POS_RIGHT_HI) begin
          right_next[{pm5[1:0], 3'b000} +: 8] = in_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      pos       <= 4'd0;
      crc       <= CRC_INIT;
      left_asm  <= 32'd0;
      right_asm <= 32'd0;
    end else begin
      in_frame  <= in_frame_next;
      pos       <= pos_next;
      crc       <= crc_next;
      left_asm  <= left_next;
      right_asm <= right_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= POS_LAST)
    else $error("byte position past frame end");
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (pos == 4'd0 && crc == CRC_INIT))
    else $error("idle with stale frame state");
  a_push_ends: assert property (@(posedge clk) disable iff (rst)
    res_push |=> !in_frame)
    else $error("frame did not close after result");

endmodule

`default_nettype wire

FILE: rtl/core/scfr_out_buf.sv
// scfr_out_buf: result register with a skid stage toward the output stream.
// depends on scfr_pkg.
`default_nettype none

module scfr_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire scfr_pkg::result_t push_data,
  output logic                   can_take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output scfr_pkg::result_t      out_data
);
  import scfr_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  assign can_take = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a word ahead of the output");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("word pushed into a full buffer");
  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("output word changed while waiting");

endmodule

`default_nettype wire

FILE: rtl/core/sync_crc8_frame_receiver_unit.sv
// sync_crc8_frame_receiver_unit: top level, apb register and stream ports.
// depends on scfr_pkg, scfr_frame, scfr_out_buf.
//
// Byte stream in, one checked result word out per frame. While idle, bytes
// are dropped until one matches the sync register (reset 90); that byte opens
// a frame of FRAME_LEN bytes and every later byte belongs to the frame. A
// reflected crc-8 (poly 0x8C, init 0) covers bytes 0 to FRAME_LEN-3, the last
// byte is the checksum, bytes 1-4 and 5-8 form two little-endian signed
// counts, zeroed when the checksum fails. One byte is taken every cycle: the
// crc step is a combinational xor network and the result goes into a
// registered output stage with a skid entry, so s_tready drops only when both
// entries hold words. The result of a frame's last byte goes to the output
// register, or to the skid entry while the output word waits for m_tready.
`default_nettype none

module sync_crc8_frame_receiver_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [scfr_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,   // rx_byte
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [scfr_pkg::M_DATA_W-1:0]      m_tdata    // frame_ok, left_count, right_count
);
  import scfr_pkg::*;

  logic    [7:0] sync_byte;
  logic          in_accept;
  logic          res_push;
  result_t       res_data;
  result_t       out_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SYNC_IDX) ? {24'd0, sync_byte} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= SYNC_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SYNC_IDX) begin
      sync_byte <= pwdata[7:0];
    end
  end

  assign in_accept = s_tvalid && s_tready;

  scfr_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .sync_byte (sync_byte),
    .in_accept (in_accept),
    .in_byte   (s_tdata),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  scfr_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .can_take  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {{(M_DATA_W - RESULT_W){1'b0}}, out_data};

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[64:1] == 64'd0))
    else $error("failed frame carries nonzero counts");

endmodule

`default_nettype wire
